// ===== hw/rtl/ili_pkg.sv =====
`default_nettype none

package ili_pkg;

    // Port widths fixed by the interface
    localparam int CMD_BITS  = 2;
    localparam int TIME_BITS = 64;
    localparam int KIND_BITS = 3;

    // Input commands
    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_REFINE = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // Result kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_INTERSECT = 3'd0,
        KIND_PASS      = 3'd1,
        KIND_END_OK    = 3'd2,
        KIND_END_NONE  = 3'd3,
        KIND_LOAD_FULL = 3'd4
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // input beat taken this cycle
        logic issue;    // read the next table entry
        logic flush;    // walk finished, release held result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;     // table empty
        logic addr_last;    // current read address is the last entry
        logic pipe_empty;   // no table entry in flight
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ili_ram.sv =====
`default_nettype none

module ili_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ili_ctrl.sv =====
`default_nettype none

module ili_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ili_pkg::CMD_BITS-1:0]  command,
    input  wire ili_pkg::dp_stat_t             stat,
    output logic                               busy,
    output ili_pkg::ctrl_cmd_t                 ctrl
);

    import ili_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next   = state_reg;
        ctrl.accept  = 1'b0;
        ctrl.issue   = 1'b0;
        ctrl.flush   = 1'b0;
        busy         = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                ctrl.accept = start;
                if (start && (cmd_t'(command) == CMD_REFINE) && !stat.cnt_zero)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                ctrl.issue = 1'b1;
                if (stat.addr_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    ctrl.flush = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ili_dp.sv =====
`default_nettype none

module ili_dp #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_WIDTH  = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [ili_pkg::CMD_BITS-1:0]         command,
    input  wire logic signed [ili_pkg::TIME_BITS-1:0] interval_start,
    input  wire logic signed [ili_pkg::TIME_BITS-1:0] interval_stop,
    input  wire ili_pkg::ctrl_cmd_t                   ctrl,
    output ili_pkg::dp_stat_t                         stat,
    output logic signed [ili_pkg::TIME_BITS-1:0]      out_start,
    output logic signed [ili_pkg::TIME_BITS-1:0]      out_stop,
    output logic [ili_pkg::KIND_BITS-1:0]             result_kind,
    output logic                                      last_of_run,
    output logic                                      result_valid
);

    import ili_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int TW = TIME_WIDTH;

    // Times trimmed to the working width
    logic signed [TW-1:0] s_in, e_in;
    assign s_in = interval_start[TW-1:0];
    assign e_in = interval_stop[TW-1:0];

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 seen_reg, seen_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic signed [TW-1:0] cand_s_reg, cand_s_next, cand_e_reg, cand_e_next;
    logic                 rd_vld_reg, hl_vld_reg;
    logic signed [TW-1:0] hi_reg, hi_next, lo_reg, lo_next;
    logic signed [TW-1:0] pend_s_reg, pend_s_next, pend_e_reg, pend_e_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 ov_reg, ov_next;
    logic signed [TW-1:0] os_reg, os_next, oe_reg, oe_next;
    kind_t                okind_reg, okind_next;
    logic                 olast_reg, olast_next;

    logic                 we;
    logic [2*TW-1:0]      rdata;
    logic signed [TW-1:0] rs, re_t;
    logic                 full;

    // Reference table, start in the upper half, stop in the lower
    ili_ram #(
        .WIDTH(2 * TW),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (we),
        .waddr(cnt_reg[AW-1:0]),
        .wdata({s_in, e_in}),
        .re   (ctrl.issue),
        .raddr(addr_reg),
        .rdata(rdata)
    );

    assign rs   = rdata[2*TW-1:TW];
    assign re_t = rdata[TW-1:0];
    assign full = (cnt_reg == CW'(TABLE_DEPTH));

    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.addr_last  = ((CW'(addr_reg) + CW'(1)) == cnt_reg);
    assign stat.pipe_empty = !rd_vld_reg && !hl_vld_reg;

    // Overlap of candidate and entry, registered before the order test
    assign hi_next = (cand_s_reg <= rs) ? rs : cand_s_reg;
    assign lo_next = (cand_e_reg <= re_t) ? cand_e_reg : re_t;

    // Command decode, result hold and output beat
    always_comb
    begin
        cnt_next      = cnt_reg;
        seen_next     = seen_reg;
        addr_next     = addr_reg;
        cand_s_next   = cand_s_reg;
        cand_e_next   = cand_e_reg;
        pend_s_next   = pend_s_reg;
        pend_e_next   = pend_e_reg;
        pend_vld_next = pend_vld_reg;
        ov_next       = 1'b0;
        os_next       = os_reg;
        oe_next       = oe_reg;
        okind_next    = okind_reg;
        olast_next    = olast_reg;
        we            = 1'b0;

        if (ctrl.accept)
        begin
            unique case (cmd_t'(command))
                CMD_LOAD:
                begin
                    if (!full)
                    begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        os_next    = '0;
                        oe_next    = '0;
                        okind_next = KIND_LOAD_FULL;
                        olast_next = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    cnt_next  = '0;
                    seen_next = 1'b0;
                end
                CMD_REFINE:
                begin
                    seen_next   = 1'b1;
                    cand_s_next = s_in;
                    cand_e_next = e_in;
                    addr_next   = '0;
                    if (cnt_reg == '0)
                    begin
                        ov_next    = 1'b1;
                        os_next    = s_in;
                        oe_next    = e_in;
                        okind_next = KIND_PASS;
                        olast_next = 1'b1;
                    end
                end
                CMD_END:
                begin
                    ov_next    = 1'b1;
                    os_next    = '0;
                    oe_next    = '0;
                    okind_next = seen_reg ? KIND_END_OK : KIND_END_NONE;
                    olast_next = 1'b1;
                end
                default:
                begin
                    cnt_next = cnt_reg;
                end
            endcase
        end

        if (ctrl.issue)
        begin
            addr_next = addr_reg + AW'(1);
        end

        // Hold each hit until the next one or the flush so the final one can carry the last mark
        if (hl_vld_reg && (hi_reg <= lo_reg))
        begin
            if (pend_vld_reg)
            begin
                ov_next    = 1'b1;
                os_next    = pend_s_reg;
                oe_next    = pend_e_reg;
                okind_next = KIND_INTERSECT;
                olast_next = 1'b0;
            end
            pend_s_next   = hi_reg;
            pend_e_next   = lo_reg;
            pend_vld_next = 1'b1;
        end

        if (ctrl.flush)
        begin
            if (pend_vld_reg)
            begin
                ov_next    = 1'b1;
                os_next    = pend_s_reg;
                oe_next    = pend_e_reg;
                okind_next = KIND_INTERSECT;
                olast_next = 1'b1;
            end
            pend_vld_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            seen_reg     <= 1'b0;
            rd_vld_reg   <= 1'b0;
            hl_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            seen_reg     <= seen_next;
            rd_vld_reg   <= ctrl.issue;
            hl_vld_reg   <= rd_vld_reg;
            pend_vld_reg <= pend_vld_next;
            ov_reg       <= ov_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        cand_s_reg <= cand_s_next;
        cand_e_reg <= cand_e_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        pend_s_reg <= pend_s_next;
        pend_e_reg <= pend_e_next;
        os_reg     <= os_next;
        oe_reg     <= oe_next;
        okind_reg  <= okind_next;
        olast_reg  <= olast_next;
    end

    assign out_start    = TIME_BITS'(os_reg);
    assign out_stop     = TIME_BITS'(oe_reg);
    assign result_kind  = okind_reg;
    assign last_of_run  = olast_reg;
    assign result_valid = ov_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/interval_list_intersector.sv =====
// Interval list intersector.
// Input: one command beat is taken at a rising edge with start high and busy
// low. command selects load, clear, refine or end; interval_start and
// interval_stop carry the times (low TIME_WIDTH bits used, sign extended).
// Output: each result is shown for one cycle with result_valid high;
// last_of_run marks the final result of a command. No backpressure exists.
// Timing and throughput:
//   load, clear, end: busy stays low, a new beat every cycle.
//     A dropped load or an end gives its result the cycle after the beat.
//   refine with an empty table: one pass-through result the next cycle.
//   refine with N stored entries: busy while the table RAM is
//     read one entry per cycle and while a two-stage overlap pipeline drains.
//     Hits come out in load order, the last one once the walk is done.
// Reset clears the entry count, the candidate flag and all control state;
// table contents are left as they are and only read below the count.
// Results cannot be stalled, so no result is ever dropped.
`default_nettype none

module interval_list_intersector #(
    parameter int TABLE_DEPTH = 64,
    parameter int TIME_WIDTH  = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [ili_pkg::CMD_BITS-1:0]         command,
    input  wire logic signed [ili_pkg::TIME_BITS-1:0] interval_start,
    input  wire logic signed [ili_pkg::TIME_BITS-1:0] interval_stop,
    output logic                                      result_valid,
    output logic signed [ili_pkg::TIME_BITS-1:0]      out_start,
    output logic signed [ili_pkg::TIME_BITS-1:0]      out_stop,
    output logic [ili_pkg::KIND_BITS-1:0]             result_kind,
    output logic                                      last_of_run
);

    import ili_pkg::*;

    ctrl_cmd_t ctrl;
    dp_stat_t  stat;

    // Sequencer
    ili_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .command(command),
        .stat   (stat),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    // Table, overlap pipeline and result register
    ili_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .interval_start(interval_start),
        .interval_stop (interval_stop),
        .ctrl          (ctrl),
        .stat          (stat),
        .out_start     (out_start),
        .out_stop      (out_stop),
        .result_kind   (result_kind),
        .last_of_run   (last_of_run),
        .result_valid  (result_valid)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ili_checker.sv =====
`default_nettype none

module ili_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 start,
    input wire logic                                 busy,
    input wire logic [ili_pkg::CMD_BITS-1:0]         command,
    input wire logic                                 result_valid,
    input wire logic signed [ili_pkg::TIME_BITS-1:0] out_start,
    input wire logic signed [ili_pkg::TIME_BITS-1:0] out_stop,
    input wire logic [ili_pkg::KIND_BITS-1:0]        result_kind,
    input wire logic                                 last_of_run
);

    import ili_pkg::*;

    // Every kind but an intersection is the only result of its beat
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind != KIND_INTERSECT) |-> last_of_run)
        else $error("status result without last mark");

    // Intersections are never reversed
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_INTERSECT) |-> (out_start <= out_stop))
        else $error("intersection with start after stop");

    // Status-only results carry zero times
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && ((result_kind == KIND_END_OK) || (result_kind == KIND_END_NONE)
            || (result_kind == KIND_LOAD_FULL))
        |-> (out_start == '0) && (out_stop == '0))
        else $error("status result with nonzero times");

    // A clear produces no result
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_CLEAR) |=> !result_valid)
        else $error("result after clear");

endmodule

bind interval_list_intersector ili_checker u_ili_checker (.*);

`default_nettype wire

// ===== verif/interval_list_intersector_chk.sv =====
module interval_list_intersector_chk
    import ili_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [CMD_BITS-1:0]         command,
    input  logic signed [TIME_BITS-1:0] interval_start,
    input  logic signed [TIME_BITS-1:0] interval_stop,
    input  logic                        result_valid,
    input  logic signed [TIME_BITS-1:0] out_start,
    input  logic signed [TIME_BITS-1:0] out_stop,
    input  logic [KIND_BITS-1:0]        result_kind,
    input  logic                        last_of_run,
    output int                          fail_count,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [TIME_BITS-1:0] stamp_t;

    typedef struct {
        stamp_t t_start;
        stamp_t t_stop;
        kind_t  kind;
        logic   last;
    } span_result_t;

    // Shadow of the reference table and the candidate flag
    stamp_t       table_start [TABLE_DEPTH];
    stamp_t       table_stop  [TABLE_DEPTH];
    int           table_used;
    logic         candidate_seen;
    span_result_t awaited_spans[$];
    int           errors;

    initial
    begin
        table_used     = 0;
        candidate_seen = 1'b0;
        errors         = 0;
    end

    function automatic void push_span(stamp_t s, stamp_t e, kind_t k);
        span_result_t r;
        r.t_start = s;
        r.t_stop  = e;
        r.kind    = k;
        r.last    = 1'b0;
        awaited_spans = {awaited_spans, r};
    endfunction

    // Work out the results one command beat causes and update the shadow state
    function automatic void intersect_with_table(cmd_t c, stamp_t s, stamp_t e);
        int     first;
        stamp_t hi;
        stamp_t lo;
        first = awaited_spans.size();
        case (c)
            CMD_LOAD:
            begin
                if (table_used < TABLE_DEPTH)
                begin
                    table_start[table_used] = s;
                    table_stop[table_used]  = e;
                    table_used++;
                end
                else
                begin
                    push_span('0, '0, KIND_LOAD_FULL);
                end
            end
            CMD_CLEAR:
            begin
                table_used     = 0;
                candidate_seen = 1'b0;
            end
            CMD_REFINE:
            begin
                candidate_seen = 1'b1;
                if (table_used == 0)
                begin
                    push_span(s, e, KIND_PASS);
                end
                else
                begin
                    // later start, earlier stop; touching ends count as overlap
                    for (int j = 0; j < table_used; j++)
                    begin
                        hi = (s <= table_start[j]) ? table_start[j] : s;
                        lo = (e <= table_stop[j]) ? e : table_stop[j];
                        if (hi <= lo)
                            push_span(hi, lo, KIND_INTERSECT);
                    end
                end
            end
            default:
            begin
                push_span('0, '0, candidate_seen ? KIND_END_OK : KIND_END_NONE);
            end
        endcase
        if (awaited_spans.size() > first)
            awaited_spans[awaited_spans.size() - 1].last = 1'b1;
    endfunction

    // Compare result beats first, then predict from the command beat of this edge
    always @(posedge clk)
    begin
        span_result_t want;
        if (!rst_n)
        begin
            table_used     = 0;
            candidate_seen = 1'b0;
            awaited_spans.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_spans.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result: start=%h stop=%h kind=%0d last=%0b",
                             $time, out_start, out_stop, result_kind, last_of_run);
                end
                else
                begin
                    want = awaited_spans.pop_front();
                    if (want.t_start !== out_start || want.t_stop !== out_stop ||
                        want.kind !== result_kind || want.last !== last_of_run)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected start=%h stop=%h kind=%0d last=%0b",
                                 $time, want.t_start, want.t_stop, want.kind, want.last);
                        $display("%0t:           actual start=%h stop=%h kind=%0d last=%0b",
                                 $time, out_start, out_stop, result_kind, last_of_run);
                    end
                end
            end
            if (start && !busy)
                intersect_with_table(cmd_t'(command), interval_start, interval_stop);
        end
        fail_count <= errors;
        pending    <= awaited_spans.size();
    end

endmodule

// ===== verif/interval_list_intersector_tb.sv =====
module interval_list_intersector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ili_pkg::*;

    localparam int MAX_CYCLES   = 200000;
    localparam int DRAIN_CYCLES = 80;
    localparam int TOTAL_ITEMS  = 330;
    localparam int TABLE_DEPTH  = 64;

    localparam logic signed [TIME_BITS-1:0] T_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [TIME_BITS-1:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic [CMD_BITS-1:0]         command = CMD_LOAD;
    logic signed [TIME_BITS-1:0] interval_start = '0;
    logic signed [TIME_BITS-1:0] interval_stop = '0;
    logic                        busy;
    logic                        result_valid;
    logic signed [TIME_BITS-1:0] out_start;
    logic signed [TIME_BITS-1:0] out_stop;
    logic [KIND_BITS-1:0]        result_kind;
    logic                        last_of_run;
    int                          fail_count;
    int                          pending;

    // stimulus state
    int                          beats_sent = 0;
    bit                          steady = 1'b0;
    logic signed [TIME_BITS-1:0] anchor = '0;

    interval_list_intersector #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .interval_start (interval_start),
        .interval_stop  (interval_stop),
        .result_valid   (result_valid),
        .out_start      (out_start),
        .out_stop       (out_stop),
        .result_kind    (result_kind),
        .last_of_run    (last_of_run)
    );

    interval_list_intersector_chk #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .interval_start (interval_start),
        .interval_stop  (interval_stop),
        .result_valid   (result_valid),
        .out_start      (out_start),
        .out_stop       (out_stop),
        .result_kind    (result_kind),
        .last_of_run    (last_of_run),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic signed [TIME_BITS-1:0] rand_time();
        return {$urandom, $urandom};
    endfunction

    // a time within a couple thousand ticks of the sequence anchor
    function automatic logic signed [TIME_BITS-1:0] near_anchor();
        logic signed [TIME_BITS-1:0] off;
        off = TIME_BITS'($urandom_range(0, 4000));
        return anchor + off - 64'sd2000;
    endfunction

    // Mostly short spans near the anchor, some reversed, some extreme or wild
    task automatic make_span(output logic signed [TIME_BITS-1:0] s,
                             output logic signed [TIME_BITS-1:0] e);
        int                          pick;
        logic signed [TIME_BITS-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            s = rand_time();
            e = rand_time();
        end
        else if (pick < 14)
        begin
            s = $urandom_range(0, 1) ? T_MIN : near_anchor();
            e = $urandom_range(0, 1) ? T_MAX : near_anchor();
        end
        else
        begin
            len = TIME_BITS'($urandom_range(0, 3000));
            s   = near_anchor();
            e   = s + len - 64'sd100;
        end
    endtask

    // One command beat; random idle cycles first unless steady, then hold until taken
    task automatic send(cmd_t c, logic signed [TIME_BITS-1:0] s,
                        logic signed [TIME_BITS-1:0] e);
        // stop sending once the beat budget is used up
        if (beats_sent >= TOTAL_ITEMS)
            return;
        while (!steady && $urandom_range(0, 99) < 32)
        begin
            start          <= 1'b0;
            command        <= cmd_t'($urandom_range(0, 3));
            interval_start <= rand_time();
            interval_stop  <= rand_time();
            @(posedge clk);
        end
        start          <= 1'b1;
        command        <= c;
        interval_start <= s;
        interval_stop  <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_span(cmd_t c);
        logic signed [TIME_BITS-1:0] s;
        logic signed [TIME_BITS-1:0] e;
        make_span(s, e);
        send(c, s, e);
    endtask

    // Stimulus and verdict
    initial
    begin
        int seq;
        int loads;
        int refines;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: end before any candidate, pass-through, clear, edge overlaps
        send(CMD_END, T_MAX, T_MIN);
        send(CMD_REFINE, T_MIN, T_MAX);
        send(CMD_REFINE, T_MAX, T_MIN);
        send(CMD_END, '0, '0);
        send(CMD_CLEAR, T_MIN, T_MAX);
        send(CMD_END, '0, '0);
        send(CMD_LOAD, T_MIN, T_MAX);
        send(CMD_LOAD, 64'sd1000, 64'sd500);
        send(CMD_LOAD, -64'sd200, 64'sd0);
        send(CMD_LOAD, 64'sd300, 64'sd700);
        send(CMD_REFINE, 64'sd0, 64'sd300);
        send(CMD_REFINE, 64'sd800, 64'sd900);
        send(CMD_REFINE, 64'sd600, 64'sd400);
        send(CMD_REFINE, T_MIN, T_MIN);
        send(CMD_REFINE, T_MAX, T_MAX);
        send(CMD_END, T_MAX, T_MAX);
        send(CMD_CLEAR, '0, '0);
        send(CMD_LOAD, T_MAX, T_MAX);
        send(CMD_REFINE, T_MIN, T_MAX);
        send(CMD_CLEAR, rand_time(), rand_time());

        // random: clear, loads, refines, end; sometimes a full table; some noise
        seq = 0;
        while (beats_sent < TOTAL_ITEMS)
        begin
            seq++;
            steady = (seq >= 8 && seq < 16);
            anchor = rand_time();
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 4))
                    send(cmd_t'($urandom_range(0, 3)), rand_time(), rand_time());
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    send(CMD_CLEAR, rand_time(), rand_time());
                if (seq == 1 || $urandom_range(0, 19) == 0)
                    loads = $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 3);
                else
                    loads = $urandom_range(0, 8);
                repeat (loads)
                    send_span(CMD_LOAD);
                refines = $urandom_range(0, 4);
                repeat (refines)
                    send_span(CMD_REFINE);
                if ($urandom_range(0, 5) != 0)
                    send(CMD_END, rand_time(), rand_time());
            end
        end
        start <= 1'b0;
        @(posedge clk);

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        for (int cyc = 0; cyc < MAX_CYCLES; cyc++)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

endmodule
